[rtl/i2r_pkg.sv]
// Shared types and constants for the integer to Roman numeral emitter.
package i2r_pkg;

    // Input value width and the top of the convertible range
    localparam int VALUE_W   = 12;
    localparam int MAX_VALUE = 3999;

    // Output letter width (7-bit ASCII)
    localparam int LETTER_W  = 7;

    // Decimal digit layout: thousands fit in two bits, the rest are full BCD
    localparam int DIGIT_W   = 4;
    localparam int THOU_W    = 2;
    localparam int BCD_W     = 4 * DIGIT_W;

    // Binary to BCD conversion: shift-add-3 passes per cycle and cycle count
    localparam int DD_BITS   = 3;
    localparam int DD_STEPS  = VALUE_W / DD_BITS;

    // One classified job handed from the front end to the letter sequencer
    typedef struct packed {
        logic                err;
        logic [THOU_W-1:0]   thou;
        logic [DIGIT_W-1:0]  hund;
        logic [DIGIT_W-1:0]  tens;
        logic [DIGIT_W-1:0]  ones;
    } job_t;

endpackage

[rtl/i2r_front.sv]
// Front end: takes a value beat, range-checks it and converts it to decimal digits.
module i2r_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [i2r_pkg::VALUE_W-1:0] value,
    input  logic                        push,
    output logic                        full,
    input  logic                        q_full,
    output logic                        q_push,
    output i2r_pkg::job_t               job
);
    import i2r_pkg::*;

    localparam int STEP_W = (DD_STEPS > 1) ? $clog2(DD_STEPS) : 1;
    localparam int ACC_W  = BCD_W + VALUE_W;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DD_STEPS - 1);

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic                err_reg, err_next;
    logic [ACC_W-1:0]    acc;
    logic                accept;
    logic                final_step;

    // One shift-add-3 pass over the BCD digits and the remaining binary bits
    function automatic logic [ACC_W-1:0] dd_shift(input logic [ACC_W-1:0] x);
        logic [ACC_W-1:0] y;
        y = x;
        for (int i = 0; i < 4; i++) begin
            if (y[VALUE_W + DIGIT_W*i +: DIGIT_W] >= DIGIT_W'(5)) begin
                y[VALUE_W + DIGIT_W*i +: DIGIT_W] =
                    y[VALUE_W + DIGIT_W*i +: DIGIT_W] + DIGIT_W'(3);
            end
        end
        return y << 1;
    endfunction

    // Several conversion passes per cycle
    always_comb
    begin
        acc = {bcd_reg, bin_reg};
        for (int j = 0; j < DD_BITS; j++) begin
            acc = dd_shift(acc);
        end
    end

    // Handshakes: hand off on the final pass, take a new beat once free
    assign final_step = busy_reg && (step_reg == LAST_STEP);
    assign q_push     = final_step && !q_full;
    assign full       = busy_reg && !q_push;
    assign accept     = push && !full;

    // Job handed to the queue
    assign job.err  = err_reg;
    assign job.thou = acc[VALUE_W + 3*DIGIT_W +: THOU_W];
    assign job.hund = acc[VALUE_W + 2*DIGIT_W +: DIGIT_W];
    assign job.tens = acc[VALUE_W + DIGIT_W +: DIGIT_W];
    assign job.ones = acc[VALUE_W +: DIGIT_W];

    // Next-state logic
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        err_next  = err_reg;
        if (accept) begin
            busy_next = 1'b1;
            step_next = '0;
            bin_next  = value;
            bcd_next  = '0;
            err_next  = (value == '0) || (value > VALUE_W'(MAX_VALUE));
        end else if (q_push) begin
            busy_next = 1'b0;
        end else if (busy_reg && !final_step) begin
            step_next = step_reg + STEP_W'(1);
            bin_next  = acc[VALUE_W-1:0];
            bcd_next  = acc[ACC_W-1:VALUE_W];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        err_reg <= err_next;
    end

endmodule

[rtl/i2r_queue.sv]
// Short job queue between the front end and the letter sequencer.
module i2r_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  i2r_pkg::job_t wr_job,
    output logic          full,
    input  logic          rd,
    output i2r_pkg::job_t rd_job,
    output logic          empty
);
    import i2r_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t              slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full   = (cnt_reg == CW'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_job = slot_reg[rd_ptr_reg];

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

[rtl/i2r_back.sv]
// Back end: walks the decimal digits of a job and emits one Roman letter per cycle unless stalled.
module i2r_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  i2r_pkg::job_t                job,
    output logic [i2r_pkg::LETTER_W-1:0] letter,
    output logic                         last,
    output logic                         range_error,
    output logic                         empty,
    input  logic                         pop
);
    import i2r_pkg::*;

    localparam int NUM_DIGITS = 4;
    localparam int POS_W      = $clog2(NUM_DIGITS);
    localparam int LEN_W      = 3;

    localparam logic [LETTER_W-1:0] CH_NONE = LETTER_W'(0);
    localparam logic [LETTER_W-1:0] CH_I = LETTER_W'(8'h49);
    localparam logic [LETTER_W-1:0] CH_V = LETTER_W'(8'h56);
    localparam logic [LETTER_W-1:0] CH_X = LETTER_W'(8'h58);
    localparam logic [LETTER_W-1:0] CH_L = LETTER_W'(8'h4C);
    localparam logic [LETTER_W-1:0] CH_C = LETTER_W'(8'h43);
    localparam logic [LETTER_W-1:0] CH_D = LETTER_W'(8'h44);
    localparam logic [LETTER_W-1:0] CH_M = LETTER_W'(8'h4D);

    // Letter groups by digit position, thousands first
    localparam logic [LETTER_W-1:0] ONE_SYM  [NUM_DIGITS] = '{CH_M, CH_C, CH_X, CH_I};
    localparam logic [LETTER_W-1:0] FIVE_SYM [NUM_DIGITS] = '{CH_NONE, CH_D, CH_L, CH_V};
    localparam logic [LETTER_W-1:0] TEN_SYM  [NUM_DIGITS] = '{CH_NONE, CH_M, CH_C, CH_X};

    logic [DIGIT_W-1:0]  dig_reg   [NUM_DIGITS];
    logic [DIGIT_W-1:0]  dig_next  [NUM_DIGITS];
    logic [DIGIT_W-1:0]  dig_after [NUM_DIGITS];
    logic [1:0]          k_reg, k_next;
    logic                err_pend_reg, err_pend_next;
    logic [LETTER_W-1:0] letter_reg, letter_next;
    logic                last_reg, last_next;
    logic                rerr_reg, rerr_next;
    logic                out_valid_reg, out_valid_next;

    logic [POS_W-1:0]    cur_pos;
    logic [DIGIT_W-1:0]  cur_d;
    logic [LEN_W-1:0]    cur_len;
    logic                digit_done;
    logic                active;
    logic                emit;
    logic                final_letter;
    logic [LETTER_W-1:0] cur_letter;

    // Number of letters a decimal digit takes
    function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
        logic [LEN_W-1:0] n;
        if (d < DIGIT_W'(4)) begin
            n = LEN_W'(d);
        end else if (d == DIGIT_W'(4) || d == DIGIT_W'(9)) begin
            n = LEN_W'(2);
        end else begin
            n = LEN_W'(d - DIGIT_W'(4));
        end
        return n;
    endfunction

    // Letter k of a digit's run
    function automatic logic [LETTER_W-1:0] digit_letter(
        input logic [DIGIT_W-1:0]  d,
        input logic [1:0]          k,
        input logic [LETTER_W-1:0] one,
        input logic [LETTER_W-1:0] five,
        input logic [LETTER_W-1:0] ten
    );
        logic [LETTER_W-1:0] ch;
        priority if (d < DIGIT_W'(4)) begin
            ch = one;
        end else if (d == DIGIT_W'(4)) begin
            ch = (k == 2'd0) ? one : five;
        end else if (d < DIGIT_W'(9)) begin
            ch = (k == 2'd0) ? five : one;
        end else begin
            ch = (k == 2'd0) ? one : ten;
        end
        return ch;
    endfunction

    // Pick the leading nonzero digit and its letter
    always_comb
    begin
        active = err_pend_reg;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            active = active || (dig_reg[i] != '0);
        end

        cur_pos = POS_W'(NUM_DIGITS - 1);
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
            if (dig_reg[i] != '0) begin
                cur_pos = POS_W'(i);
            end
        end

        cur_d      = dig_reg[cur_pos];
        cur_len    = digit_len(cur_d);
        digit_done = ({1'b0, k_reg} == (cur_len - LEN_W'(1)));
        cur_letter = digit_letter(cur_d, k_reg, ONE_SYM[cur_pos],
                                  FIVE_SYM[cur_pos], TEN_SYM[cur_pos]);

        dig_after = dig_reg;
        if (digit_done) begin
            dig_after[cur_pos] = '0;
        end

        final_letter = 1'b1;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            final_letter = final_letter && (dig_after[i] == '0);
        end
        final_letter = final_letter || err_pend_reg;
    end

    // Emit when the output register is free or drains this cycle
    assign emit  = active && (!out_valid_reg || pop);
    assign q_pop = !q_empty && (!active || (emit && final_letter));

    // Next-state logic
    always_comb
    begin
        dig_next       = dig_reg;
        k_next         = k_reg;
        err_pend_next  = err_pend_reg;
        letter_next    = letter_reg;
        last_next      = last_reg;
        rerr_next      = rerr_reg;
        out_valid_next = out_valid_reg;

        if (emit) begin
            out_valid_next = 1'b1;
            letter_next    = err_pend_reg ? CH_NONE : cur_letter;
            last_next      = final_letter;
            rerr_next      = err_pend_reg;
            err_pend_next  = 1'b0;
            if (!err_pend_reg) begin
                dig_next = dig_after;
                k_next   = digit_done ? 2'd0 : k_reg + 2'd1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end

        // Load the next job; an errored job carries no digits
        if (q_pop) begin
            err_pend_next = job.err;
            k_next        = 2'd0;
            if (job.err) begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    dig_next[i] = '0;
                end
            end else begin
                dig_next[0] = DIGIT_W'(job.thou);
                dig_next[1] = job.hund;
                dig_next[2] = job.tens;
                dig_next[3] = job.ones;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                dig_reg[i] <= '0;
            end
            k_reg         <= 2'd0;
            err_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            dig_reg       <= dig_next;
            k_reg         <= k_next;
            err_pend_reg  <= err_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
        last_reg   <= last_next;
        rerr_reg   <= rerr_next;
    end

    assign letter      = letter_reg;
    assign last        = last_reg;
    assign range_error = rerr_reg;
    assign empty       = !out_valid_reg;

endmodule

[rtl/integer_to_roman_emitter.sv]
// Top level of the integer to Roman numeral emitter.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+----------------------------
//  input    | in        | push / full          | value[11:0]
//  result   | out       | empty / pop          | letter[6:0], last, range_error
//
// The front end range-checks a value and converts it to decimal digits with
// 3 shift-add-3 passes per cycle; the back end emits one letter beat per cycle
// while the result is not stalled, 1 to 15 letters for each value.
// Reset is asynchronous and clears all control state; no clearing pass.
// A stalled result holds in the output register while the job queue and the
// front end keep taking values until the queue fills.
module integer_to_roman_emitter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [i2r_pkg::VALUE_W-1:0]  value,
    input  logic                         push,
    output logic                         full,
    output logic [i2r_pkg::LETTER_W-1:0] letter,
    output logic                         last,
    output logic                         range_error,
    output logic                         empty,
    input  logic                         pop
);
    import i2r_pkg::*;

    job_t front_job;
    job_t back_job;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    i2r_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (value),
        .push   (push),
        .full   (full),
        .q_full (q_full),
        .q_push (q_push),
        .job    (front_job)
    );

    i2r_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_push),
        .wr_job (front_job),
        .full   (q_full),
        .rd     (q_pop),
        .rd_job (back_job),
        .empty  (q_empty)
    );

    i2r_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .job         (back_job),
        .letter      (letter),
        .last        (last),
        .range_error (range_error),
        .empty       (empty),
        .pop         (pop)
    );

    // An out-of-range result is a single blank letter that closes its run
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && range_error) |-> (last && letter == '0))
        else $error("range error beat is not a closing blank letter");

    // Every in-range beat carries a real letter
    a_letter_set: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !range_error) |-> (letter != '0))
        else $error("in-range beat carries no letter");

    // The job queue is never full and empty at once
    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("job queue reports full and empty together");

    // The sequencer never pulls from an empty queue
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job queue read while empty");

endmodule
